@@ design/ppdve_pkg.sv @@
// Shared types and constants for the packet position delta varint encoder.
package ppdve_pkg;

	localparam int POS_W  = 56;
	localparam int FILE_W = 32;
	localparam int LEN_W  = 32;
	localparam int GRP_W  = 7;
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = QAW + 1;

	typedef enum logic [1:0] {
		MODE_POS   = 2'd0,
		MODE_START = 2'd1,
		MODE_END   = 2'd2
	} mode_t;

	// One queued command: a segment report or one value to encode.
	typedef struct packed {
		logic              is_report;
		logic [POS_W-1:0]  value;
		logic [FILE_W-1:0] file;
	} cmd_t;

endpackage

@@ design/ppdve_front.sv @@
// Front end: accepts items, tracks delta history and segment state, queues commands.
module ppdve_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      mode,
	input  logic [ppdve_pkg::POS_W-1:0]     packet_offset,
	input  logic [ppdve_pkg::FILE_W-1:0]    file_number,
	input  logic                            q_full,
	output logic                            push,
	output ppdve_pkg::cmd_t                 push_data
);
	import ppdve_pkg::*;

	logic              file_open_q;
	logic [POS_W-1:0]  prev_pos_q;
	logic [POS_W-1:0]  prev_gap_q;
	logic [FILE_W-1:0] open_file_q;
	logic [POS_W-1:0]  delta;
	logic              same_gap;
	logic              accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign delta    = packet_offset - prev_pos_q;
	assign same_gap = (delta == prev_gap_q);

	always_comb begin
		push               = 1'b0;
		push_data.is_report = 1'b0;
		push_data.value    = same_gap ? '0 : delta;
		push_data.file     = open_file_q;
		unique case (mode)
			MODE_POS: begin
				push = accept && file_open_q;
			end
			MODE_START, MODE_END: begin
				push                = accept && file_open_q;
				push_data.is_report = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_open_q <= 1'b0;
			prev_pos_q  <= '0;
			prev_gap_q  <= '0;
			open_file_q <= '0;
		end else if (accept) begin
			unique case (mode)
				MODE_POS: begin
					if (!same_gap)
						prev_gap_q <= delta;
					prev_pos_q <= packet_offset;
				end
				MODE_START: begin
					prev_pos_q  <= '0;
					prev_gap_q  <= '0;
					file_open_q <= 1'b1;
					open_file_q <= file_number;
				end
				MODE_END: begin
					file_open_q <= 1'b0;
				end
				default: begin
					file_open_q <= file_open_q;
				end
			endcase
		end
	end

endmodule

@@ design/ppdve_queue.sv @@
// Command queue between front end and byte emitter.
module ppdve_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ppdve_pkg::cmd_t push_data,
	input  logic            pop,
	output ppdve_pkg::cmd_t head,
	output logic            full,
	output logic            empty
);
	import ppdve_pkg::*;

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;

	assign full  = (cnt_q == QCW'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCW'(QDEPTH)) else $error("queue count overflow");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
`endif

endmodule

@@ design/ppdve_back.sv @@
// Back end: emits 7-bit groups one per cycle while out_ready is high, counts segment bytes, emits reports.
module ppdve_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ppdve_pkg::cmd_t               head,
	input  logic                          empty,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          kind,
	output logic [7:0]                    index_byte,
	output logic [ppdve_pkg::FILE_W-1:0]  segment_file,
	output logic [ppdve_pkg::LEN_W-1:0]   segment_length,
	output logic                          last
);
	import ppdve_pkg::*;

	logic              busy_q;
	logic              rep_q;
	logic [POS_W-1:0]  val_q;
	logic [FILE_W-1:0] file_q;
	logic [LEN_W-1:0]  cnt_q;
	logic              fin;
	logic              take;

	assign fin  = (val_q[POS_W-1:GRP_W] == '0);
	assign take = busy_q && out_ready;
	assign pop  = !empty && (!busy_q || (take && last));

	assign out_valid      = busy_q;
	assign kind           = rep_q;
	assign index_byte     = rep_q ? 8'd0 : {fin, val_q[GRP_W-1:0]};
	assign segment_file   = rep_q ? file_q : '0;
	assign segment_length = rep_q ? cnt_q : '0;
	assign last           = rep_q || fin;

	always_ff @(posedge clk) begin
		if (pop) begin
			rep_q  <= head.is_report;
			val_q  <= head.value;
			file_q <= head.file;
		end else if (take && !rep_q) begin
			val_q <= val_q >> GRP_W;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (pop)
				busy_q <= 1'b1;
			else if (take && last)
				busy_q <= 1'b0;
			if (take) begin
				if (rep_q)
					cnt_q <= '0;
				else if (cnt_q != '1)
					cnt_q <= cnt_q + 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_byte_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !kind) |-> (last == index_byte[7]))
		else $error("final mark and last disagree");
	a_report_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind) |-> (last && index_byte == 8'd0))
		else $error("malformed report");
	a_count_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(take && rep_q) |=> (cnt_q == '0))
		else $error("byte count not cleared after report");
`endif

endmodule

@@ design/packet_position_delta_varint_encoder.sv @@
// Top level of the packet position delta varint encoder.
//
//  channel  handshake             payload
//  in       in_valid/in_ready     mode, packet_offset, file_number
//  out      out_valid/out_ready   kind, index_byte, segment_file, segment_length, last
//
// An item is taken every cycle while the 4-entry command queue has room.
// A position emits 1 to 8 bytes, one per cycle while out_ready is high; a report is a single result.
// Sustained rate is set by the byte emitter, which pops the next command as the last result is taken.
// Reset clears the delta history, segment state and queue; no clearing pass.
// Either side may stall; the queue decouples the front end from the emitter.
module packet_position_delta_varint_encoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [ppdve_pkg::POS_W-1:0]   packet_offset,
	input  logic [ppdve_pkg::FILE_W-1:0]  file_number,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          kind,
	output logic [7:0]                    index_byte,
	output logic [ppdve_pkg::FILE_W-1:0]  segment_file,
	output logic [ppdve_pkg::LEN_W-1:0]   segment_length,
	output logic                          last
);
	import ppdve_pkg::*;

	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	cmd_t push_data;
	cmd_t head;

	ppdve_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.packet_offset(packet_offset),
		.file_number  (file_number),
		.q_full       (q_full),
		.push         (push),
		.push_data    (push_data)
	);

	ppdve_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	ppdve_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (q_empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.index_byte    (index_byte),
		.segment_file  (segment_file),
		.segment_length(segment_length),
		.last          (last)
	);

endmodule

@@ test/packet_position_delta_varint_encoder_tb.sv @@
// Testbench for the packet position delta varint encoder: directed and random items, scoreboard.
module packet_position_delta_varint_encoder_tb;
	import ppdve_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic       KIND_BYTE   = 1'b0;
	localparam logic       KIND_REPORT = 1'b1;
	localparam int         STALL_LIMIT = 5000;
	localparam int         HOLD_CYCLES = 300;

	typedef struct packed {
		logic              kind;
		logic [7:0]        index_byte;
		logic [FILE_W-1:0] segment_file;
		logic [LEN_W-1:0]  segment_length;
		logic              last;
	} enc_result_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [1:0]        mode;
	logic [POS_W-1:0]  packet_offset;
	logic [FILE_W-1:0] file_number;
	logic              out_valid;
	logic              out_ready;
	logic              kind;
	logic [7:0]        index_byte;
	logic [FILE_W-1:0] segment_file;
	logic [LEN_W-1:0]  segment_length;
	logic              last;

	// encoder model state
	logic              seg_open;
	logic [POS_W-1:0]  last_pos;
	logic [POS_W-1:0]  last_gap;
	logic [LEN_W-1:0]  seg_bytes;
	logic [FILE_W-1:0] seg_file;

	enc_result_t awaited_results[$];
	int          error_count;
	int          stall_cycles;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_req;
	int          hold_seen;
	int          hold_left;

	// stimulus-side view of positions, for building repeated gaps
	logic [POS_W-1:0] gen_pos;
	logic [POS_W-1:0] gen_gap;

	packet_position_delta_varint_encoder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.packet_offset  (packet_offset),
		.file_number    (file_number),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.index_byte     (index_byte),
		.segment_file   (segment_file),
		.segment_length (segment_length),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic enc_result_t segment_report();
		enc_result_t r;
		r.kind           = KIND_REPORT;
		r.index_byte     = 8'h00;
		r.segment_file   = seg_file;
		r.segment_length = seg_bytes;
		r.last           = 1'b1;
		return r;
	endfunction

	function automatic void encode_item(logic [1:0] m, logic [POS_W-1:0] pos,
			logic [FILE_W-1:0] fnum);
		logic [POS_W-1:0] delta;
		int               groups;
		logic [LEN_W:0]   sum;
		enc_result_t      r;
		case (m)
			MODE_START: begin
				if (seg_open)
					awaited_results.push_back(segment_report());
				last_pos  = '0;
				last_gap  = '0;
				seg_open  = 1'b1;
				seg_file  = fnum;
				seg_bytes = '0;
			end
			MODE_END: begin
				if (seg_open) begin
					awaited_results.push_back(segment_report());
					seg_open = 1'b0;
				end
			end
			MODE_POS: begin
				delta = pos - last_pos;
				if (delta == last_gap)
					delta = '0;
				else
					last_gap = delta;
				last_pos = pos;
				if (seg_open) begin
					groups = 1;
					while (groups < 8 && (delta >> (GRP_W * groups)) != '0)
						groups++;
					for (int g = 0; g < groups; g++) begin
						r.kind           = KIND_BYTE;
						r.index_byte     = {(g == groups - 1), delta[GRP_W*g +: GRP_W]};
						r.segment_file   = '0;
						r.segment_length = '0;
						r.last           = (g == groups - 1);
						awaited_results.push_back(r);
					end
					sum       = {1'b0, seg_bytes} + (LEN_W+1)'(groups);
					seg_bytes = sum[LEN_W] ? '1 : sum[LEN_W-1:0];
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
			error_count++;
		end
	endfunction

	// input prediction, output checking and stall watchdog, all at one edge
	always @(posedge clk) begin
		enc_result_t exp_r;
		if (arst_n) begin
			stall_cycles++;
			if (in_valid && in_ready) begin
				stall_cycles = 0;
				encode_item(mode, packet_offset, file_number);
			end
			if (out_valid && out_ready) begin
				stall_cycles = 0;
				if (awaited_results.size() == 0) begin
					$error("unexpected result: kind %0h byte %0h", kind, index_byte);
					error_count++;
				end else begin
					exp_r = awaited_results.pop_front();
					check_field("kind", 64'(exp_r.kind), 64'(kind));
					check_field("index_byte", 64'(exp_r.index_byte), 64'(index_byte));
					check_field("segment_file", 64'(exp_r.segment_file),
						64'(segment_file));
					check_field("segment_length", 64'(exp_r.segment_length),
						64'(segment_length));
					check_field("last", 64'(exp_r.last), 64'(last));
				end
			end
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// result side: random stalls plus requested long hold-offs
	initial begin
		out_ready = 1'b0;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_item(logic [1:0] m, logic [POS_W-1:0] pos, logic [FILE_W-1:0] fnum);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= m;
		packet_offset <= pos;
		file_number   <= fnum;
		do
			@(posedge clk);
		while (!in_ready);
		if (m == MODE_START) begin
			gen_pos = '0;
			gen_gap = '0;
		end else if (m == MODE_POS) begin
			gen_gap = pos - gen_pos;
			gen_pos = pos;
		end
	endtask

	// checks at the falling edge so the last accepted item is already predicted
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (awaited_results.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
	endtask

	function automatic logic [POS_W-1:0] rand_pos56();
		return POS_W'({$urandom(), $urandom()});
	endfunction

	function automatic logic [POS_W-1:0] next_position();
		int               pick;
		logic [63:0]      wide;
		pick = $urandom_range(0, 99);
		wide = {$urandom(), $urandom()};
		if (pick < 30)
			return gen_pos + gen_gap;
		else if (pick < 65)
			return gen_pos + POS_W'($urandom_range(1, 300));
		else if (pick < 90)
			return gen_pos + POS_W'(wide >> (64 - $urandom_range(1, POS_W)));
		else
			return rand_pos56();
	endfunction

	function automatic logic [FILE_W-1:0] rand_file();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	task automatic test_directed();
		logic [POS_W-1:0] p;
		logic [POS_W-1:0] deltas[15];
		deltas = '{56'h7f, 56'h80, 56'h3fff, 56'h4000, 56'h1fffff, 56'h200000,
			56'hfffffff, 56'h10000000, 56'h7ffffffff, 56'h800000000,
			56'h3ffffffffff, 56'h40000000000, 56'h1ffffffffffff, 56'h2000000000000,
			56'hffffffffffffff};
		set_idling(0, 0);
		send_item(MODE_END, '0, '0);
		send_item(MODE_POS, 56'd100, '0);
		send_item(MODE_UNUSED, '1, '1);
		send_item(MODE_START, '1, '0);
		send_item(MODE_POS, '0, '1);
		p = '0;
		foreach (deltas[i]) begin
			p = p + deltas[i];
			send_item(MODE_POS, p, '0);
		end
		send_item(MODE_POS, p + deltas[14], '0);
		send_item(MODE_START, '0, '1);
		send_item(MODE_POS, '1, '0);
		send_item(MODE_END, '1, '1);
		send_item(MODE_END, '0, '0);
		wait_drained();
	endtask

	task automatic send_segment();
		int n;
		n = $urandom_range(1, 8);
		send_item(MODE_START, rand_pos56(), rand_file());
		repeat (n)
			send_item(MODE_POS, next_position(), $urandom());
		if ($urandom_range(0, 99) < 75)
			send_item(MODE_END, rand_pos56(), $urandom());
	endtask

	task automatic send_noise();
		case ($urandom_range(0, 2))
			0: send_item(MODE_UNUSED, rand_pos56(), $urandom());
			1: send_item(MODE_END, rand_pos56(), $urandom());
			default: begin
				send_item(MODE_END, rand_pos56(), $urandom());
				send_item(MODE_POS, next_position(), $urandom());
			end
		endcase
	endtask

	task automatic random_burst(int items);
		int sent;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 99) < 15) begin
				send_noise();
				sent += 1;
			end else begin
				send_segment();
				sent += 5;
			end
		end
	endtask

	task automatic test_random_traffic();
		set_idling(25, 84);
		random_burst(24);
		wait_drained();
		set_idling(84, 25);
		random_burst(24);
		wait_drained();
		set_idling(0, 0);
		random_burst(24);
		wait_drained();
	endtask

	task automatic test_backpressure();
		set_idling(0, 0);
		hold_req <= hold_req + 1;
		send_item(MODE_START, rand_pos56(), rand_file());
		repeat (16)
			send_item(MODE_POS, rand_pos56(), $urandom());
		send_item(MODE_END, '0, '0);
		wait_drained();
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		mode          = MODE_POS;
		packet_offset = '0;
		file_number   = '0;
		seg_open      = 1'b0;
		last_pos      = '0;
		last_gap      = '0;
		seg_bytes     = '0;
		seg_file      = '0;
		gen_pos       = '0;
		gen_gap       = '0;
		error_count   = 0;
		stall_cycles  = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req      = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		repeat (20) @(posedge clk);
		if (error_count == 0 && awaited_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
